FILE: rtl/core/xed_pkg.sv
`default_nettype none
package xed_pkg;

  localparam int HOLD_DEPTH = 5;
  localparam int NUM_ENT    = 6;
  localparam int ENT_MAX    = 5;
  localparam int NUM_EMIT   = HOLD_DEPTH + 1;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int HCNT_W     = $clog2(HOLD_DEPTH + 1);
  localparam int EIDX_W     = $clog2(NUM_EMIT + 1);

  localparam logic [7:0] AMP = 8'h26;

  // entity bodies after the '&', padded with zero
  localparam logic [7:0] ENT_BODY [NUM_ENT][ENT_MAX] = '{
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h23, 8'h31, 8'h36, 8'h30, 8'h3B}
  };
  localparam logic [HCNT_W-1:0] ENT_LEN [NUM_ENT] = '{
    HCNT_W'(3), HCNT_W'(3), HCNT_W'(5), HCNT_W'(5), HCNT_W'(4), HCNT_W'(5)
  };
  localparam logic [7:0] ENT_VAL [NUM_ENT] = '{
    8'h3C, 8'h3E, 8'h22, 8'h27, 8'h26, 8'h20
  };

  // bytes to emit for one input transaction
  typedef struct packed {
    logic [NUM_EMIT-1:0][7:0] bytes;
    logic [EIDX_W-1:0]        n;
    logic                     last;
  } cmd_t;

  typedef struct packed {
    logic pop;
  } head_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/xed_if.sv
`default_nettype none
interface xed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface xed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_end,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/xml_entity_decoder.sv
`default_nettype none
// XML entity decoder: takes escaped text one byte per transaction and replaces
// &lt; &gt; &quot; &apos; &amp; &#160; with < > " ' & and a space. Bytes after an
// '&' are held while they may still form an entity; on a mismatch or at the
// string end they come out literally. The front end classifies one input byte
// per cycle and posts up to six output bytes into a four-entry queue; the back
// end drains one output byte per cycle while the sink is ready. An input byte
// that yields one result passes at one per cycle; a mismatch flush emits its
// bytes one by one, so the input stalls once the queue fills. run_last flags
// the final result of each input byte, string_end the final result of a string.
module xml_entity_decoder (
  input  logic      clk,
  input  logic      rst_n,
  xed_in_if.sink    in_ch,
  xed_out_if.source out_ch
);
  import xed_pkg::*;

  logic      push, q_full, head_valid;
  cmd_t      push_cmd, head;
  head_ctl_t ctl;

  xed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  xed_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (ctl.pop),
    .head       (head),
    .head_valid (head_valid)
  );

  xed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .ctl        (ctl),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

FILE: rtl/core/xed_front.sv
`default_nettype none
module xed_front (
  input  logic          clk,
  input  logic          rst_n,
  xed_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output xed_pkg::cmd_t push_cmd
);
  import xed_pkg::*;

  logic [7:0]        held_r [HOLD_DEPTH];
  logic [HCNT_W-1:0] hc_r, hc_nxt;
  logic [HCNT_W-1:0] k;
  logic [7:0]        c;
  logic              acc;
  logic              full_hit, prefix_hit, extend, ent_ok;
  logic [7:0]        full_val;
  cmd_t              cmd;

  assign c   = in_ch.in_byte;
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;
  assign k   = (hc_r == '0) ? '0 : hc_r - HCNT_W'(1);

  always_comb begin
    full_hit   = 1'b0;
    prefix_hit = 1'b0;
    full_val   = '0;
    for (int e = 0; e < NUM_ENT; e++) begin
      ent_ok = (hc_r != '0) && (ENT_LEN[e] >= hc_r);
      for (int j = 0; j < ENT_MAX; j++) begin
        if (HCNT_W'(j) < k && j < HOLD_DEPTH - 1) begin
          if (ENT_BODY[e][j] != held_r[j + 1]) ent_ok = 1'b0;
        end else if (HCNT_W'(j) == k) begin
          if (ENT_BODY[e][j] != c) ent_ok = 1'b0;
        end
      end
      if (ent_ok && ENT_LEN[e] == hc_r) begin
        full_hit = 1'b1;
        full_val = full_val | ENT_VAL[e];
      end
      if (ent_ok && ENT_LEN[e] > hc_r) prefix_hit = 1'b1;
    end
  end

  assign extend = !full_hit && prefix_hit && (hc_r < HCNT_W'(HOLD_DEPTH));

  always_comb begin
    cmd.last = in_ch.in_last;
    for (int i = 0; i < NUM_EMIT; i++) begin
      if (i < HOLD_DEPTH && HCNT_W'(i) < hc_r) cmd.bytes[i] = held_r[i];
      else                                     cmd.bytes[i] = c;
    end
    if (full_hit) begin
      cmd.bytes[0] = full_val;
      cmd.n        = EIDX_W'(1);
    end else if (extend) begin
      cmd.n = in_ch.in_last ? EIDX_W'(hc_r) + EIDX_W'(1) : '0;
    end else begin
      cmd.n = EIDX_W'(hc_r) + ((c != AMP || in_ch.in_last) ? EIDX_W'(1) : '0);
    end
  end

  always_comb begin
    hc_nxt = hc_r;
    if (acc) begin
      if (full_hit || in_ch.in_last) hc_nxt = '0;
      else if (extend)               hc_nxt = hc_r + HCNT_W'(1);
      else if (c == AMP)             hc_nxt = HCNT_W'(1);
      else                           hc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= '0;
    end else begin
      hc_r <= hc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !full_hit) begin
      if (extend) held_r[hc_r[HCNT_W-1:0]] <= c;
      else        held_r[0] <= c;
    end
  end

  assign push     = acc && (cmd.n != '0);
  assign push_cmd = cmd;

endmodule
`default_nettype wire

FILE: rtl/core/xed_queue.sv
`default_nettype none
module xed_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xed_pkg::cmd_t     push_cmd,
  output logic              full,
  input  logic              pop,
  output xed_pkg::cmd_t     head,
  output logic              head_valid
);
  import xed_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !do_pop)      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push && do_pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

FILE: rtl/core/xed_back.sv
`default_nettype none
module xed_back (
  input  logic               clk,
  input  logic               rst_n,
  input  xed_pkg::cmd_t      head,
  input  logic               head_valid,
  output xed_pkg::head_ctl_t ctl,
  xed_out_if.source          out_ch
);
  import xed_pkg::*;

  logic [EIDX_W-1:0] idx_r, idx_nxt;
  logic              final_byte, take;

  assign final_byte = (idx_r == head.n - EIDX_W'(1));
  assign take       = out_ch.valid && out_ch.ready;

  assign out_ch.valid      = head_valid;
  assign out_ch.out_byte   = head.bytes[idx_r];
  assign out_ch.run_last   = final_byte;
  assign out_ch.string_end = final_byte && head.last;

  assign ctl.pop   = take && final_byte;

  always_comb begin
    idx_nxt = idx_r;
    if (take) idx_nxt = final_byte ? '0 : idx_r + EIDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: test/xed_checker.sv
`timescale 1ns / 1ps

module xed_checker (
  input  logic clk,
  input  logic rst_n,
  xed_in_if    in_mon,
  xed_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int          NUM_ENT   = 6;
  localparam int          HOLD_MAX  = 5;
  localparam logic [7:0]  AMP_CH    = 8'h26;
  localparam logic [39:0] ENT_TXT [NUM_ENT] =
    '{"lt;", "gt;", "quot;", "apos;", "amp;", "#160;"};
  localparam int          ENT_LEN [NUM_ENT] = '{3, 3, 5, 5, 4, 5};
  localparam logic [7:0]  ENT_OUT [NUM_ENT] = '{8'h3C, 8'h3E, 8'h22, 8'h27, 8'h26, 8'h20};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } dec_byte_t;

  dec_byte_t  decoded_q[$];
  logic [7:0] held [HOLD_MAX];
  logic [2:0] held_n;

  function automatic logic [7:0] ent_char(input int e, input int j);
    return ENT_TXT[e][(ENT_LEN[e] - 1 - j) * 8 +: 8];
  endfunction

  // decode one accepted byte, queue the bytes it releases
  function automatic void decode_byte(input logic [7:0] c, input logic last);
    logic [7:0] emit_q[$];
    int         k;
    int         full;
    bit         prefix;
    bit         ok;
    dec_byte_t  r;
    if (held_n == 0) begin
      if (c == AMP_CH) begin
        held[0] = c;
        held_n  = 1;
      end else begin
        emit_q = {emit_q, c};
      end
    end else begin
      k      = int'(held_n) - 1;
      prefix = 0;
      full   = -1;
      for (int e = 0; e < NUM_ENT; e++) begin
        if (ENT_LEN[e] < k + 1) continue;
        ok = 1;
        for (int j = 0; j < k; j++)
          if (ent_char(e, j) != held[j + 1]) ok = 0;
        if (!ok || ent_char(e, k) != c) continue;
        if (ENT_LEN[e] == k + 1) full = e;
        else prefix = 1;
      end
      if (full >= 0) begin
        held_n = 0;
        emit_q = {emit_q, ENT_OUT[full]};
      end else if (prefix && held_n < HOLD_MAX) begin
        held[held_n] = c;
        held_n++;
      end else begin
        for (int i = 0; i < held_n; i++) emit_q = {emit_q, held[i]};
        held_n = 0;
        if (c == AMP_CH) begin
          held[0] = c;
          held_n  = 1;
        end else begin
          emit_q = {emit_q, c};
        end
      end
    end
    if (last) begin
      for (int i = 0; i < held_n; i++) emit_q = {emit_q, held[i]};
      held_n = 0;
    end
    foreach (emit_q[i]) begin
      r.out_byte   = emit_q[i];
      r.run_last   = (i == emit_q.size() - 1);
      r.string_end = last && (i == emit_q.size() - 1);
      decoded_q    = {decoded_q, r};
    end
  endfunction

  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst_n) begin
      held_n     = 0;
      fail_count = 0;
      decoded_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        decode_byte(in_mon.in_byte, in_mon.in_last);
      if (out_mon.valid && out_mon.ready) begin
        if (decoded_q.size() == 0) begin
          $error("out_byte: expected none, actual %02h", out_mon.out_byte);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_mon.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, out_mon.out_byte);
            fail_count++;
          end
          if (out_mon.run_last !== want.run_last) begin
            $error("run_last: expected %0b, actual %0b", want.run_last, out_mon.run_last);
            fail_count++;
          end
          if (out_mon.string_end !== want.string_end) begin
            $error("string_end: expected %0b, actual %0b", want.string_end,
                   out_mon.string_end);
            fail_count++;
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   items_sent;
  int   idle_cycles;
  bit   idle_en;
  bit   rx_hold;

  string ents [6] = '{"&lt;", "&gt;", "&quot;", "&apos;", "&amp;", "&#160;"};

  xed_in_if  in_ch ();
  xed_out_if out_ch ();

  xml_entity_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  xed_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit coin();
    return $urandom_range(0, 19) == 0;
  endfunction

  // entered and left at a falling edge
  task automatic send(input logic [7:0] b, input logic l);
    int g;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      g = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // full entity, broken entity, string end inside a match, or a plain byte
  task automatic send_piece();
    int kind;
    int e;
    int n;
    kind = $urandom_range(0, 99);
    e    = $urandom_range(0, 5);
    n    = $urandom_range(1, ents[e].len() - 1);
    if (kind < 45) begin
      send_str(ents[e], coin());
    end else if (kind < 70) begin
      send_str(ents[e].substr(0, n - 1), 1'b0);
      send(8'($urandom_range(0, 255)), coin());
    end else if (kind < 80) begin
      send_str(ents[e].substr(0, n - 1), 1'b1);
    end else begin
      send(8'($urandom_range(0, 255)), coin());
    end
  endtask

  initial begin
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end else if (!idle_en || $urandom_range(0, 5) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        n = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_last <= 1'b0;
    rst_n         <= 1'b0;
    idle_en       = 1'b1;
    rx_hold       = 1'b0;
    items_sent    = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_str("&lt;", 1'b0);
    send_str("&gt;", 1'b0);
    send_str("&aposx", 1'b0);   // longest flush: six bytes out of one
    send_str("&&", 1'b0);
    send(8'hFF, 1'b1);
    send(8'h00, 1'b0);
    send(8'h26, 1'b1);          // lone '&' at string end
    send_str("&quot;", 1'b1);

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    // sink held off while the source keeps pushing
    idle_en = 1'b0;
    rx_hold = 1'b1;
    while (items_sent < 75) send_piece();

    idle_en = 1'b1;
    while (items_sent < 290) begin
      if ($urandom_range(0, 9) == 0) idle_en = ~idle_en;
      send_piece();
    end

    idle_en = 1'b0;
    while (items_sent < 330) send_piece();
    send(8'($urandom_range(0, 255)), 1'b1);

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
